@@ src/macd_pkg.sv @@
// Shared types and constants for the MACD indicator block.
`timescale 1ns / 1ps
`default_nettype none

package macd_pkg;

    // Gain registers: unsigned Q1.16, 65536 is one
    localparam int GAIN_WIDTH = 17;
    localparam int GAIN_FRAC  = 16;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 17'd65536;

    localparam logic [GAIN_WIDTH-1:0] FAST_GAIN_RESET   = 17'd10082;
    localparam logic [GAIN_WIDTH-1:0] SLOW_GAIN_RESET   = 17'd4855;
    localparam logic [GAIN_WIDTH-1:0] SIGNAL_GAIN_RESET = 17'd13107;

    // Configuration register map
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FAST_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOW_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNAL_GAIN = 2'd2;

    // Width of one slice of the magnitude fed to the shared multiplier
    localparam int MUL_CHUNK = 32;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIRST,
        OP_SETUP,
        OP_MUL,
        OP_FINISH,
        OP_DIF,
        OP_SEED,
        OP_HDIFF,
        OP_MAGS,
        OP_OUT
    } dp_op_t;

    // Which average an EMA step works on
    typedef enum logic [1:0] {
        SEL_FAST,
        SEL_SLOW,
        SEL_SIG
    } ema_sel_t;

    typedef struct packed {
        dp_op_t   op;
        ema_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic seeded;
        logic mul_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/macd_indicator.sv @@
// Top level of the MACD indicator: controller plus datapath.
//
// One input word per bar: close_price and series_start, on in_valid/in_ready.
// One result word per bar: diff_line, signal_line, histogram on
// out_valid/out_ready. Gains are written on cfg_valid/cfg_ready with
// cfg_index (0 fast, 1 slow, 2 signal) and cfg_data; cfg_ready is always high
// and other indexes are ignored.
// The block works on one bar at a time. A single 32x17 multiplier is shared
// by the three EMA updates, each working through its magnitude in
// N = ceil((PRICE_WIDTH+FRAC_BITS+1)/32) slices of 32 bits. The first bar of
// a series only seeds the averages; the second bar runs the fast and slow
// updates and seeds the signal average; later bars run all three updates.
// The next bar can be accepted in the same cycle as the result is raised.
// in_ready is high only while the controller is idle; a finished result sits
// in the output register, so the next bar is taken while it waits. If the
// result is still not taken when the next one is ready, the block holds in
// its last step until out_ready. Reset restores the default gains and marks
// the next bar as the first of a series; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module macd_indicator #(
    parameter int PRICE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [PRICE_WIDTH-1:0]               close_price,
    input  wire logic                                 series_start,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [PRICE_WIDTH:0]               diff_line,
    output logic signed [PRICE_WIDTH:0]               signal_line,
    output logic signed [PRICE_WIDTH+2:0]             histogram,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [macd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [macd_pkg::GAIN_WIDTH-1:0]      cfg_data
);

    import macd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    macd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    macd_datapath #(
        .PRICE_WIDTH (PRICE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .close_price  (close_price),
        .series_start (series_start),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .diff_line    (diff_line),
        .signal_line  (signal_line),
        .histogram    (histogram)
    );

    // One bar in flight: no second word is taken right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a bar is in work");

    // A result only appears at the end of a bar's work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while idle");

    // Multiply steps only run while a bar is in work
    a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MUL |-> !in_ready && !$past(in_valid && in_ready))
        else $error("multiply step outside a bar");

endmodule

`default_nettype wire

@@ src/macd_datapath.sv @@
// Datapath: gain registers, EMA state, shared multiplier and output rounding.
`timescale 1ns / 1ps
`default_nettype none

module macd_datapath #(
    parameter int PRICE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire macd_pkg::dp_cmd_t                    cmd,
    output macd_pkg::dp_status_t                      status,
    input  wire logic [PRICE_WIDTH-1:0]               close_price,
    input  wire logic                                 series_start,
    input  wire logic                                 cfg_valid,
    input  wire logic [macd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [macd_pkg::GAIN_WIDTH-1:0]      cfg_data,
    output logic signed [PRICE_WIDTH:0]               diff_line,
    output logic signed [PRICE_WIDTH:0]               signal_line,
    output logic signed [PRICE_WIDTH+2:0]             histogram
);

    import macd_pkg::*;

    localparam int QW     = PRICE_WIDTH + FRAC_BITS;   // fast/slow average
    localparam int SW     = QW + 1;                    // dif and signal average
    localparam int DW     = QW + 2;                    // EMA difference, hist/2
    localparam int MW     = DW - 1;                    // EMA difference magnitude
    localparam int NCHUNK = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PADW   = NCHUNK * MUL_CHUNK;
    localparam int AW     = PADW + GAIN_WIDTH;
    localparam int PRODW  = MUL_CHUNK + GAIN_WIDTH;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int HW     = QW + 2;                    // histogram magnitude

    localparam logic [1:0] BARS_NONE = 2'd0;
    localparam logic [1:0] BARS_ONE  = 2'd1;
    localparam logic [1:0] BARS_MANY = 2'd2;

    // Configuration and series state
    logic [GAIN_WIDTH-1:0]  fast_gain_reg, slow_gain_reg, signal_gain_reg;
    logic [1:0]             bars_reg;
    logic [PRICE_WIDTH-1:0] close_reg;
    logic                   start_reg;
    logic [QW-1:0]          fast_reg, slow_reg;
    logic signed [SW-1:0]   sig_reg, dif_reg;

    // EMA step working registers
    logic                   neg_reg;
    logic [MW-1:0]          mag_reg;
    logic [GAIN_WIDTH-1:0]  gain_reg;
    logic [AW-1:0]          acc_reg;
    logic [CW-1:0]          idx_reg;

    // Output working registers
    logic signed [DW-1:0]   hd_reg;
    logic [QW-1:0]          dmag_reg, smag_reg;
    logic [HW-1:0]          hmag_reg;
    logic                   dneg_reg, sneg_reg, hneg_reg;
    logic signed [PRICE_WIDTH:0]   diff_line_reg, signal_line_reg;
    logic signed [PRICE_WIDTH+2:0] histogram_reg;

    // Setup: operand select, difference and magnitude
    logic [QW-1:0]          cq;
    logic signed [DW-1:0]   x_sel, e_sel, diff, diff_abs;
    logic [GAIN_WIDTH-1:0]  g_raw, g_clip;

    assign cq = {close_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        case (cmd.sel)
            SEL_FAST:
            begin
                x_sel = signed'({2'b00, cq});
                e_sel = signed'({2'b00, fast_reg});
                g_raw = fast_gain_reg;
            end
            SEL_SLOW:
            begin
                x_sel = signed'({2'b00, cq});
                e_sel = signed'({2'b00, slow_reg});
                g_raw = slow_gain_reg;
            end
            SEL_SIG:
            begin
                x_sel = signed'({dif_reg[SW-1], dif_reg});
                e_sel = signed'({sig_reg[SW-1], sig_reg});
                g_raw = signal_gain_reg;
            end
            default:
            begin
                x_sel = '0;
                e_sel = '0;
                g_raw = '0;
            end
        endcase
    end

    assign diff     = x_sel - e_sel;
    assign diff_abs = diff[DW-1] ? -diff : diff;
    assign g_clip   = (g_raw > GAIN_ONE) ? GAIN_ONE : g_raw;

    // Multiply step: one slice of the magnitude times the gain
    logic [PADW-1:0]      mag_pad;
    logic [MUL_CHUNK-1:0] chunk;
    logic [PRODW-1:0]     prod;
    logic [AW-1:0]        acc_next;

    assign mag_pad  = {{(PADW - MW){1'b0}}, mag_reg};
    assign chunk    = mag_pad[idx_reg * MUL_CHUNK +: MUL_CHUNK];
    assign prod     = PRODW'(chunk) * PRODW'(gain_reg);
    assign acc_next = acc_reg + (AW'(prod) << (idx_reg * MUL_CHUNK));

    // Finish: round to nearest, restore sign, add to the average
    logic [AW-1:0]        acc_round;
    logic [MW-1:0]        p_mag;
    logic signed [DW-1:0] step, fast_sum, slow_sum, sig_sum;

    assign acc_round = (acc_reg + (AW'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    assign p_mag     = acc_round[MW-1:0];
    assign step      = neg_reg ? -signed'({1'b0, p_mag}) : signed'({1'b0, p_mag});
    assign fast_sum  = signed'({2'b00, fast_reg}) + step;
    assign slow_sum  = signed'({2'b00, slow_reg}) + step;
    assign sig_sum   = signed'({sig_reg[SW-1], sig_reg}) + step;

    // Output arithmetic
    logic signed [SW-1:0] dif_abs, sig_abs, new_dif;
    logic signed [DW-1:0] hd_next, hd_abs;
    logic [QW:0]          d_round, s_round;
    logic [HW:0]          h_round;
    logic [PRICE_WIDTH:0]   d_r, s_r;
    logic [PRICE_WIDTH+2:0] h_r;

    assign new_dif = signed'({1'b0, fast_reg}) - signed'({1'b0, slow_reg});
    assign hd_next = signed'({dif_reg[SW-1], dif_reg}) - signed'({sig_reg[SW-1], sig_reg});
    assign dif_abs = dif_reg[SW-1] ? -dif_reg : dif_reg;
    assign sig_abs = sig_reg[SW-1] ? -sig_reg : sig_reg;
    assign hd_abs  = hd_reg[DW-1] ? -hd_reg : hd_reg;

    assign d_round = ({1'b0, dmag_reg} + ((QW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign s_round = ({1'b0, smag_reg} + ((QW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign h_round = ({1'b0, hmag_reg} + ((HW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign d_r     = d_round[PRICE_WIDTH:0];
    assign s_r     = s_round[PRICE_WIDTH:0];
    assign h_r     = h_round[PRICE_WIDTH+2:0];

    // Status to the controller
    assign status.first    = start_reg || (bars_reg == BARS_NONE);
    assign status.seeded   = (bars_reg == BARS_MANY);
    assign status.mul_last = (idx_reg == CW'(NCHUNK - 1));

    // Control state: gain registers and bar count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_gain_reg   <= FAST_GAIN_RESET;
            slow_gain_reg   <= SLOW_GAIN_RESET;
            signal_gain_reg <= SIGNAL_GAIN_RESET;
            bars_reg        <= BARS_NONE;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FAST_GAIN:   fast_gain_reg   <= cfg_data;
                    CFG_SLOW_GAIN:   slow_gain_reg   <= cfg_data;
                    CFG_SIGNAL_GAIN: signal_gain_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.op == OP_FIRST)
                bars_reg <= BARS_ONE;
            else if (cmd.op == OP_SEED)
                bars_reg <= BARS_MANY;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                close_reg <= close_price;
                start_reg <= series_start;
            end
            OP_FIRST:
            begin
                fast_reg  <= cq;
                slow_reg  <= cq;
                sig_reg   <= '0;
                dif_reg   <= '0;
                start_reg <= 1'b0;
            end
            OP_SETUP:
            begin
                neg_reg  <= diff[DW-1];
                mag_reg  <= diff_abs[MW-1:0];
                gain_reg <= g_clip;
                acc_reg  <= '0;
                idx_reg  <= '0;
            end
            OP_MUL:
            begin
                acc_reg <= acc_next;
                idx_reg <= idx_reg + CW'(1);
            end
            OP_FINISH:
            begin
                case (cmd.sel)
                    SEL_FAST: fast_reg <= fast_sum[QW-1:0];
                    SEL_SLOW: slow_reg <= slow_sum[QW-1:0];
                    SEL_SIG:  sig_reg  <= sig_sum[SW-1:0];
                    default:  ;
                endcase
            end
            OP_DIF:
                dif_reg <= new_dif;
            OP_SEED:
                sig_reg <= dif_reg;
            OP_HDIFF:
                hd_reg <= hd_next;
            OP_MAGS:
            begin
                dmag_reg <= dif_abs[QW-1:0];
                smag_reg <= sig_abs[QW-1:0];
                hmag_reg <= {hd_abs[MW-1:0], 1'b0};
                dneg_reg <= dif_reg[SW-1];
                sneg_reg <= sig_reg[SW-1];
                hneg_reg <= hd_reg[DW-1];
            end
            OP_OUT:
            begin
                diff_line_reg   <= dneg_reg ? -signed'(d_r) : signed'(d_r);
                signal_line_reg <= sneg_reg ? -signed'(s_r) : signed'(s_r);
                histogram_reg   <= hneg_reg ? -signed'(h_r) : signed'(h_r);
            end
            default: ;
        endcase
    end

    assign diff_line   = diff_line_reg;
    assign signal_line = signal_line_reg;
    assign histogram   = histogram_reg;

endmodule

`default_nettype wire

@@ src/macd_ctrl.sv @@
// Controller: sequences the EMA steps and the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module macd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output macd_pkg::dp_cmd_t         cmd,
    input  wire macd_pkg::dp_status_t status
);

    import macd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_MUL,
        S_FIN,
        S_DIF,
        S_SEED,
        S_HDIFF,
        S_MAGS,
        S_OUT
    } state_t;

    state_t   state_reg, state_next;
    ema_sel_t sel_reg, sel_next;
    logic     out_valid_reg, out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.sel        = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    sel_next   = SEL_FAST;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.first)
                begin
                    cmd.op     = OP_FIRST;
                    state_next = S_HDIFF;
                end
                else
                begin
                    cmd.op     = OP_SETUP;
                    state_next = S_MUL;
                end
            end
            S_SETUP:
            begin
                cmd.op     = OP_SETUP;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (status.mul_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FINISH;
                case (sel_reg)
                    SEL_FAST:
                    begin
                        sel_next   = SEL_SLOW;
                        state_next = S_SETUP;
                    end
                    SEL_SLOW:
                        state_next = S_DIF;
                    default:
                        state_next = S_HDIFF;
                endcase
            end
            S_DIF:
            begin
                cmd.op = OP_DIF;
                if (status.seeded)
                begin
                    sel_next   = SEL_SIG;
                    state_next = S_SETUP;
                end
                else
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.op     = OP_SEED;
                state_next = S_HDIFF;
            end
            S_HDIFF:
            begin
                cmd.op     = OP_HDIFF;
                state_next = S_MAGS;
            end
            S_MAGS:
            begin
                cmd.op     = OP_MAGS;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_FAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
